/* hdl/wsfr_pkg.sv */
// Shared types and constants for the WebSocket frame receiver.
// No dependencies; used by the front end, the queue and the output stage.
`default_nettype none
package wsfr_pkg;

  localparam logic [3:0] OpText   = 4'd1;
  localparam logic [3:0] OpBinary = 4'd2;
  localparam logic [3:0] OpPing   = 4'd9;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] ExtUpperLimit = 4'd4;

  localparam logic [1:0] KindText   = 2'd0;
  localparam logic [1:0] KindBinary = 2'd1;
  localparam logic [1:0] KindPong   = 2'd2;
  localparam logic [1:0] KindError  = 2'd3;

  // Result class as decided by the front end.
  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_EMPTY,
    CLS_PONG,
    CLS_ERROR
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic       binary;
    logic [7:0] data;
    logic       last;
  } entry_t;

endpackage
`default_nettype wire

/* hdl/wsfr_front.sv */
// Front end: header parser that accepts received bytes and classifies them.
// Uses wsfr_pkg; pushes one queue entry per byte that yields a result.
`default_nettype none
module wsfr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            message_end_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output wsfr_pkg::entry_t     entry_o
);

  typedef enum logic [2:0] {
    PH_HANDSHAKE,
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] pay_left_q, pay_left_d;

  logic        acc;
  logic        done;
  logic [31:0] done_len;
  logic        last;

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    len_left_d = len_left_q;
    len_acc_d  = len_acc_q;
    pay_left_d = pay_left_q;
    done       = 1'b0;
    done_len   = '0;
    last       = 1'b0;
    push_o     = 1'b0;
    entry_o    = '{cls: wsfr_pkg::CLS_DATA, binary: 1'b0, data: rx_byte_i, last: 1'b0};
    if (acc) begin
      unique case (phase_q)
        PH_HANDSHAKE: begin
          if (message_end_i) phase_d = PH_HDR0;
        end
        PH_HDR0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          len_acc_d = '0;
          if (rx_byte_i[6:0] == wsfr_pkg::Len7Ext16) begin
            len_left_d = wsfr_pkg::ExtBytes16;
            phase_d    = PH_EXTLEN;
          end else if (rx_byte_i[6:0] == wsfr_pkg::Len7Ext64) begin
            len_left_d = wsfr_pkg::ExtBytes64;
            phase_d    = PH_EXTLEN;
          end else begin
            done     = 1'b1;
            done_len = {25'd0, rx_byte_i[6:0]};
          end
        end
        PH_EXTLEN: begin
          if (len_left_q > wsfr_pkg::ExtUpperLimit && rx_byte_i != 8'd0) begin
            phase_d = PH_STOPPED;
            push_o  = 1'b1;
            entry_o = '{cls: wsfr_pkg::CLS_ERROR, binary: 1'b0, data: 8'd0, last: 1'b1};
          end else begin
            len_acc_d  = {len_acc_q[23:0], rx_byte_i};
            len_left_d = len_left_q - 4'd1;
            if (len_left_q == 4'd1) begin
              done     = 1'b1;
              done_len = {len_acc_q[23:0], rx_byte_i};
            end
          end
        end
        PH_PAYLOAD: begin
          pay_left_d = pay_left_q - 32'd1;
          last       = (pay_left_q == 32'd1);
          if (last) phase_d = PH_HDR0;
          if (opcode_q == wsfr_pkg::OpText || opcode_q == wsfr_pkg::OpBinary) begin
            push_o  = 1'b1;
            entry_o = '{cls: wsfr_pkg::CLS_DATA, binary: (opcode_q == wsfr_pkg::OpBinary),
                        data: rx_byte_i, last: last};
          end else if (opcode_q == wsfr_pkg::OpPing && last) begin
            push_o  = 1'b1;
            entry_o = '{cls: wsfr_pkg::CLS_PONG, binary: 1'b0, data: 8'd0, last: 1'b1};
          end
        end
        PH_STOPPED: begin
        end
        default: begin
        end
      endcase
      // Header complete: enter payload or finish a zero-length frame.
      if (done) begin
        pay_left_d = done_len;
        if (done_len != 32'd0) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HDR0;
          if (opcode_q == wsfr_pkg::OpText || opcode_q == wsfr_pkg::OpBinary) begin
            push_o  = 1'b1;
            entry_o = '{cls: wsfr_pkg::CLS_EMPTY, binary: (opcode_q == wsfr_pkg::OpBinary),
                        data: 8'd0, last: 1'b1};
          end else if (opcode_q == wsfr_pkg::OpPing) begin
            push_o  = 1'b1;
            entry_o = '{cls: wsfr_pkg::CLS_PONG, binary: 1'b0, data: 8'd0, last: 1'b1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HANDSHAKE;
      opcode_q   <= '0;
      len_left_q <= '0;
      len_acc_q  <= '0;
      pay_left_q <= '0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      len_left_q <= len_left_d;
      len_acc_q  <= len_acc_d;
      pay_left_q <= pay_left_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/wsfr_fifo.sv */
// Short result queue between the front end and the output stage.
// Uses wsfr_pkg for the entry type.
`default_nettype none
module wsfr_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire wsfr_pkg::entry_t entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output wsfr_pkg::entry_t      entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  wsfr_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/wsfr_back.sv */
// Output stage: turns queue entries into result fields in an output register.
// Uses wsfr_pkg for the entry type and result kind codes.
`default_nettype none
module wsfr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire wsfr_pkg::entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            payload_byte_o,
  output logic                  frame_last_o,
  output logic                  empty_frame_o
);

  logic       valid_q;
  logic [1:0] kind_d;
  logic [7:0] byte_d;
  logic       last_d;
  logic       empty_d;

  assign pop_o       = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;

  always_comb begin
    kind_d  = wsfr_pkg::KindError;
    byte_d  = 8'd0;
    last_d  = 1'b1;
    empty_d = 1'b0;
    unique case (entry_i.cls)
      wsfr_pkg::CLS_DATA: begin
        kind_d = entry_i.binary ? wsfr_pkg::KindBinary : wsfr_pkg::KindText;
        byte_d = entry_i.data;
        last_d = entry_i.last;
      end
      wsfr_pkg::CLS_EMPTY: begin
        kind_d  = entry_i.binary ? wsfr_pkg::KindBinary : wsfr_pkg::KindText;
        empty_d = 1'b1;
      end
      wsfr_pkg::CLS_PONG:  kind_d = wsfr_pkg::KindPong;
      wsfr_pkg::CLS_ERROR: kind_d = wsfr_pkg::KindError;
      default:             kind_d = wsfr_pkg::KindError;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_o         <= kind_d;
      payload_byte_o <= byte_d;
      frame_last_o   <= last_d;
      empty_frame_o  <= empty_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/websocket_frame_receiver.sv */
// Top level of the WebSocket frame receiver: front end, result queue, output stage.
// Depends on wsfr_pkg, wsfr_front, wsfr_fifo and wsfr_back.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o  | rx_byte_i, message_end_i
//   out     | out_valid_o / out_ready_i| kind_o, payload_byte_o, frame_last_o,
//           |                          | empty_frame_o
//
// One byte is taken every cycle while the result queue has room; the header parser
// handles it as accepted; each result goes via the queue into the output register.
// in_ready_o drops only when the QueueDepth-entry result queue is full.
// rst_ni clears parser state and queue; parsing restarts with the handshake discard.
`default_nettype none
module websocket_frame_receiver #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       message_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            frame_last_o,
  output logic            empty_frame_o
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  wsfr_pkg::entry_t push_entry;
  wsfr_pkg::entry_t head_entry;

  wsfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .message_end_i(message_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  wsfr_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  wsfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_last_o  (frame_last_o),
    .empty_frame_o (empty_frame_o)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_websocket_frame_receiver.sv */
// Self-checking testbench for websocket_frame_receiver: random frames between scripted
// bytes, scored against a byte-level deframer model or given values; random stalls.
// Depends on wsfr_pkg and the websocket_frame_receiver RTL.
`default_nettype none
module tb_websocket_frame_receiver;

  localparam int          SendBytes  = 850;
  localparam int          HoldCycles = 150;
  localparam int          DrainWait  = 20;
  localparam int          CycleLimit = 300000;
  localparam logic [3:0]  OpPong     = 4'hA;

  typedef enum logic [2:0] {
    PH_SKIP_REPLY,
    PH_OPCODE,
    PH_LENGTH,
    PH_EXT_LENGTH,
    PH_PAYLOAD,
    PH_HALTED
  } deframe_phase_e;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_GIVEN
  } row_check_e;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_code_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       is_last;
    logic       is_empty;
  } ws_result_t;

  typedef struct {
    logic [7:0] rx;
    logic       msg_end;
    row_check_e chk;
    ws_result_t res;
  } stim_row_t;

  localparam ws_result_t NoResult     = '0;
  localparam ws_result_t ResTextEmpty = '{wsfr_pkg::KindText, 8'h00, 1'b1, 1'b1};
  localparam ws_result_t ResBinEmpty  = '{wsfr_pkg::KindBinary, 8'h00, 1'b1, 1'b1};
  localparam ws_result_t ResPong      = '{wsfr_pkg::KindPong, 8'h00, 1'b1, 1'b0};
  localparam ws_result_t ResError     = '{wsfr_pkg::KindError, 8'h00, 1'b1, 1'b0};

  localparam int HeadRows  = 26;
  localparam int ScriptLen = 32;

  stim_row_t script [0:ScriptLen-1] = '{
    '{8'h48, 1'b0, CHK_SILENT, NoResult},   // handshake reply
    '{8'hFF, 1'b0, CHK_SILENT, NoResult},
    '{8'h0A, 1'b1, CHK_SILENT, NoResult},   // reply ends here, byte dropped
    '{8'h81, 1'b0, CHK_MODEL,  NoResult},   // empty text
    '{8'h00, 1'b0, CHK_GIVEN,  ResTextEmpty},
    '{8'h02, 1'b0, CHK_MODEL,  NoResult},   // binary, fin clear, mask set, len 1
    '{8'h81, 1'b0, CHK_MODEL,  NoResult},
    '{8'hFF, 1'b0, CHK_GIVEN,  '{wsfr_pkg::KindBinary, 8'hFF, 1'b1, 1'b0}},
    '{8'h89, 1'b0, CHK_MODEL,  NoResult},   // empty ping
    '{8'h80, 1'b0, CHK_GIVEN,  ResPong},
    '{8'h01, 1'b1, CHK_MODEL,  NoResult},   // text, 16-bit length, message_end ignored
    '{8'hFE, 1'b0, CHK_MODEL,  NoResult},
    '{8'h00, 1'b0, CHK_MODEL,  NoResult},
    '{8'h02, 1'b0, CHK_MODEL,  NoResult},
    '{8'h00, 1'b0, CHK_MODEL,  NoResult},
    '{8'h80, 1'b1, CHK_MODEL,  NoResult},
    '{8'h89, 1'b0, CHK_MODEL,  NoResult},   // ping with one payload byte
    '{8'h01, 1'b0, CHK_MODEL,  NoResult},
    '{8'hAB, 1'b0, CHK_GIVEN,  ResPong},
    '{8'h8A, 1'b0, CHK_MODEL,  NoResult},   // pong frame, consumed
    '{8'h01, 1'b0, CHK_MODEL,  NoResult},
    '{8'h55, 1'b0, CHK_MODEL,  NoResult},
    '{8'h00, 1'b0, CHK_MODEL,  NoResult},   // continuation, consumed
    '{8'h00, 1'b0, CHK_MODEL,  NoResult},
    '{8'h82, 1'b0, CHK_MODEL,  NoResult},   // empty binary
    '{8'h00, 1'b0, CHK_GIVEN,  ResBinEmpty},
    '{8'h82, 1'b0, CHK_MODEL,  NoResult},   // 64-bit length, upper word nonzero
    '{8'hFF, 1'b0, CHK_MODEL,  NoResult},
    '{8'h00, 1'b0, CHK_MODEL,  NoResult},
    '{8'h01, 1'b0, CHK_GIVEN,  ResError},
    '{8'h81, 1'b1, CHK_SILENT, NoResult},   // halted until reset
    '{8'h7E, 1'b0, CHK_SILENT, NoResult}
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] rx_byte_i     = 8'h00;
  logic       message_end_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic       frame_last_o;
  logic       empty_frame_o;

  websocket_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_last_o  (frame_last_o),
    .empty_frame_o (empty_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // deframer model state
  deframe_phase_e ph       = PH_SKIP_REPLY;
  logic [3:0]     cur_op   = 4'd0;
  logic [3:0]     ext_left = 4'd0;
  logic [31:0]    len_acc  = 32'd0;
  logic [31:0]    pay_left = 32'd0;

  ws_result_t pending_results [$];
  int         error_count    = 0;
  int         results_seen   = 0;
  int         pongs_seen     = 0;
  int         bytes_in       = 0;
  int         frames_sent    = 0;
  int         burst_left     = 0;
  int         cycle_count    = 0;
  bit         random_phase   = 1'b0;

  function automatic logic close_header(input logic [31:0] len, output ws_result_t r);
    r = NoResult;
    pay_left = len;
    if (len != 32'd0) begin
      ph = PH_PAYLOAD;
      return 1'b0;
    end
    ph = PH_OPCODE;
    case (cur_op)
      wsfr_pkg::OpText: begin
        r = ResTextEmpty;
        return 1'b1;
      end
      wsfr_pkg::OpBinary: begin
        r = ResBinEmpty;
        return 1'b1;
      end
      wsfr_pkg::OpPing: begin
        r = ResPong;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic deframe_byte(input logic [7:0] b, input logic msg_end,
                                        output ws_result_t r);
    logic is_last;
    r = NoResult;
    case (ph)
      PH_SKIP_REPLY: begin
        if (msg_end) ph = PH_OPCODE;
        return 1'b0;
      end
      PH_OPCODE: begin
        cur_op = b[3:0];
        ph = PH_LENGTH;
        return 1'b0;
      end
      PH_LENGTH: begin
        len_acc = 32'd0;
        if (b[6:0] == wsfr_pkg::Len7Ext16 || b[6:0] == wsfr_pkg::Len7Ext64) begin
          ext_left = (b[6:0] == wsfr_pkg::Len7Ext16) ? wsfr_pkg::ExtBytes16
                                                     : wsfr_pkg::ExtBytes64;
          ph = PH_EXT_LENGTH;
          return 1'b0;
        end
        return close_header({25'd0, b[6:0]}, r);
      end
      PH_EXT_LENGTH: begin
        if (ext_left > wsfr_pkg::ExtUpperLimit && b != 8'h00) begin
          ph = PH_HALTED;
          r = ResError;
          return 1'b1;
        end
        len_acc = {len_acc[23:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) return close_header(len_acc, r);
        return 1'b0;
      end
      PH_PAYLOAD: begin
        pay_left = pay_left - 32'd1;
        is_last = (pay_left == 32'd0);
        if (is_last) ph = PH_OPCODE;
        if (cur_op == wsfr_pkg::OpText || cur_op == wsfr_pkg::OpBinary) begin
          r = '{(cur_op == wsfr_pkg::OpText) ? wsfr_pkg::KindText : wsfr_pkg::KindBinary,
                b, is_last, 1'b0};
          return 1'b1;
        end
        if (cur_op == wsfr_pkg::OpPing && is_last) begin
          r = ResPong;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Called at a rising edge; returns at the accepting edge or after a random idle gap.
  task automatic push_byte(input logic [7:0] b, input logic msg_end, input row_check_e chk,
                           input ws_result_t given);
    ws_result_t r;
    logic       got;
    int         gap;
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    message_end_i <= msg_end;
    do @(negedge clk_i); while (!in_ready_o);
    got = deframe_byte(b, msg_end, r);
    if (chk == CHK_GIVEN) pending_results.push_back(given);
    else if (chk == CHK_MODEL && got) pending_results.push_back(r);
    @(posedge clk_i);
    bytes_in++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin : stimulus
    int          sel;
    int          nbytes;
    logic [3:0]  op;
    logic [31:0] len;
    logic [63:0] len_wide;
    logic        mask;
    len_code_e   code;
    logic [6:0]  len7;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < HeadRows; i++)
      push_byte(script[i].rx, script[i].msg_end, script[i].chk, script[i].res);

    random_phase = 1'b1;
    while (bytes_in < HeadRows + SendBytes) begin
      sel = $urandom_range(0, 99);
      if (sel < 35)      op = wsfr_pkg::OpText;
      else if (sel < 70) op = wsfr_pkg::OpBinary;
      else if (sel < 80) op = wsfr_pkg::OpPing;
      else if (sel < 85) op = OpPong;
      else               op = 4'($urandom_range(0, 15));

      sel = $urandom_range(0, 99);
      code = LEN_SHORT;
      if (sel < 10)      len = 32'd0;
      else if (sel < 80) len = $urandom_range(1, 20);
      else if (sel < 88) len = $urandom_range(100, 125);
      else if (sel < 95) begin
        len = $urandom_range(0, 300);
        code = LEN_EXT16;
      end else begin
        len = $urandom_range(0, 24);
        code = LEN_EXT64;
      end
      mask = 1'($urandom_range(0, 1));
      len7 = (code == LEN_EXT16) ? wsfr_pkg::Len7Ext16 :
             (code == LEN_EXT64) ? wsfr_pkg::Len7Ext64 : len[6:0];

      push_byte({4'($urandom_range(0, 15)), op}, ($urandom_range(0, 7) == 0),
                CHK_MODEL, NoResult);
      push_byte({mask, len7}, ($urandom_range(0, 7) == 0), CHK_MODEL, NoResult);
      if (code != LEN_SHORT) begin
        nbytes = (code == LEN_EXT16) ? 2 : 8;
        len_wide = {32'd0, len};
        for (int k = nbytes - 1; k >= 0; k--)
          push_byte(len_wide[8*k +: 8], ($urandom_range(0, 7) == 0), CHK_MODEL, NoResult);
      end
      for (int k = 0; k < len; k++)
        push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), CHK_MODEL,
                  NoResult);
      frames_sent++;
    end

    for (int i = HeadRows; i < ScriptLen; i++)
      push_byte(script[i].rx, script[i].msg_end, script[i].chk, script[i].res);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Fed %0d bytes (%0d random frames plus scripted frames) through the deframer,",
             bytes_in, frames_sent);
    $display("checked %0d results including %0d pong requests and the halting error.",
             results_seen, pongs_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : ready_pattern
    int  mode;
    int  seg;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (random_phase && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(10, 60);
      repeat (seg) begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(negedge clk_i) begin : result_check
    ws_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (kind_o == wsfr_pkg::KindPong) pongs_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h last %0b empty %0b",
               kind_o, payload_byte_o, frame_last_o, empty_frame_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (kind_o !== exp_res.kind) begin
          $error("kind: expected %0d, got %0d", exp_res.kind, kind_o);
          error_count++;
        end
        if (payload_byte_o !== exp_res.data) begin
          $error("payload_byte: expected %02h, got %02h", exp_res.data, payload_byte_o);
          error_count++;
        end
        if (frame_last_o !== exp_res.is_last) begin
          $error("frame_last: expected %0b, got %0b", exp_res.is_last, frame_last_o);
          error_count++;
        end
        if (empty_frame_o !== exp_res.is_empty) begin
          $error("empty_frame: expected %0b, got %0b", exp_res.is_empty, empty_frame_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
`default_nettype wire

/* filelist.f */
hdl/wsfr_pkg.sv
hdl/wsfr_front.sv
hdl/wsfr_fifo.sv
hdl/wsfr_back.sv
hdl/websocket_frame_receiver.sv
tb/sv/tb_websocket_frame_receiver.sv
